// ===== rtl/core/four_sum_quadruple_search_top_assert.svh =====
// assertion macros for the quadruple search block
`ifndef FOUR_SUM_QUADRUPLE_SEARCH_TOP_ASSERT_SVH
`define FOUR_SUM_QUADRUPLE_SEARCH_TOP_ASSERT_SVH

// same-cycle implication
`define FSQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fsq_pkg.sv =====
`default_nettype none
package fsq_pkg;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_FETCH = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_SORT_INIT,
      OP_KEY_CAP,
      OP_SHIFT,
      OP_KEY_WR,
      OP_SRCH_INIT,
      OP_INC_I,
      OP_ADV_I,
      OP_INC_J,
      OP_ADV_J,
      OP_INC_L,
      OP_DEC_R,
      OP_FIN,
      OP_SUM,
      OP_OUT_HIT,
      OP_OUT_MISS
   } dp_op_type;

   typedef enum logic [3:0] {
      RSEL_A,
      RSEL_P1,
      RSEL_I,
      RSEL_I1,
      RSEL_J,
      RSEL_J1,
      RSEL_L,
      RSEL_L1,
      RSEL_R,
      RSEL_R1
   } rsel_type;

   typedef enum logic [2:0] {
      CAP_NONE,
      CAP_I,
      CAP_J,
      CAP_L,
      CAP_R,
      CAP_T
   } cap_type;

   typedef struct packed {
      dp_op_type op;
      rsel_type  rsel;
      cap_type   cap;
      logic      csr_we;
   } cmd_type;

   typedef struct packed {
      logic a_lt_n;
      logic p_nz;
      logic tmp_gt_key;
      logic i3_ge_n;
      logic j2_ge_n;
      logic l_lt_r;
      logic i1_lt_n;
      logic j1_lt_n;
      logic eq_it;
      logic eq_jt;
      logic eq_lt;
      logic eq_rt;
      logic sum_eq;
      logic sum_gt;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/fsq_ram.sv =====
`default_nettype none
module fsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/fsq_dp.sv =====
`default_nettype none
module fsq_dp #(
   parameter int MAX_VALUES = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fsq_pkg::cmd_type     cmd,
   output fsq_pkg::sts_type          sts,
   input  wire logic signed [31:0]   req_value,
   input  wire logic signed [31:0]   csr_target_sum,
   output logic                      rsp_found,
   output logic signed [31:0]        rsp_first_value,
   output logic signed [31:0]        rsp_second_value,
   output logic signed [31:0]        rsp_third_value,
   output logic signed [31:0]        rsp_fourth_value,
   output logic                      rsp_no_more,
   output logic                      rsp_overflowed
);
   import fsq_pkg::*;

   localparam int IW = $clog2(MAX_VALUES);
   localparam int CW = $clog2(MAX_VALUES + 1);
   localparam int XW = CW + 2;
   localparam logic [CW-1:0] MAXC = CW'(MAX_VALUES);

   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic signed [31:0] target_ff, target_in;
   logic [CW-1:0] a_ff, a_in, p_ff, p_in;
   logic [XW-1:0] i_ff, i_in, j_ff, j_in, l_ff, l_in, r_ff, r_in;
   logic signed [31:0] vi_ff, vi_in, vj_ff, vj_in, vl_ff, vl_in, vr_ff, vr_in;
   logic signed [31:0] tmp_ff, tmp_in, key_ff, key_in;
   logic signed [33:0] sum_ff, sum_in;
   logic               o_found_ff, o_found_in, o_nm_ff, o_nm_in, o_ovf_ff, o_ovf_in;
   logic signed [31:0] o0_ff, o0_in, o1_ff, o1_in, o2_ff, o2_in, o3_ff, o3_in;

   logic [XW-1:0] nx, addr_full;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [31:0]   wr_data, rd_data;
   logic signed [33:0] tgt34;

   assign nx    = XW'(count_ff);
   assign tgt34 = 34'(target_ff);

   always_comb begin
      case (cmd.rsel)
         RSEL_A:  addr_full = XW'(a_ff);
         RSEL_P1: addr_full = XW'(p_ff) - XW'(1);
         RSEL_I:  addr_full = i_ff;
         RSEL_I1: addr_full = i_ff + XW'(1);
         RSEL_J:  addr_full = j_ff;
         RSEL_J1: addr_full = j_ff + XW'(1);
         RSEL_L:  addr_full = l_ff;
         RSEL_L1: addr_full = l_ff + XW'(1);
         RSEL_R:  addr_full = r_ff;
         RSEL_R1: addr_full = r_ff - XW'(1);
         default: addr_full = '0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = p_ff[IW-1:0];
      wr_data = tmp_ff;
      case (cmd.op)
         OP_LOAD: begin
            wr_en   = (count_ff < MAXC);
            wr_addr = count_ff[IW-1:0];
            wr_data = req_value;
         end
         OP_SHIFT: begin
            wr_en = 1'b1;
         end
         OP_KEY_WR: begin
            wr_en   = 1'b1;
            wr_data = key_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   fsq_ram #(
      .WIDTH (32),
      .DEPTH (MAX_VALUES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_full[IW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      target_in = cmd.csr_we ? csr_target_sum : target_ff;
      a_in = a_ff; p_in = p_ff;
      i_in = i_ff; j_in = j_ff; l_in = l_ff; r_in = r_ff;
      vi_in = vi_ff; vj_in = vj_ff; vl_in = vl_ff; vr_in = vr_ff;
      tmp_in = tmp_ff; key_in = key_ff;
      sum_in = sum_ff;
      o_found_in = o_found_ff; o_nm_in = o_nm_ff; o_ovf_in = o_ovf_ff;
      o0_in = o0_ff; o1_in = o1_ff; o2_in = o2_ff; o3_in = o3_ff;

      case (cmd.cap)
         CAP_I:   vi_in  = rd_data;
         CAP_J:   vj_in  = rd_data;
         CAP_L:   vl_in  = rd_data;
         CAP_R:   vr_in  = rd_data;
         CAP_T:   tmp_in = rd_data;
         default: tmp_in = tmp_ff;
      endcase

      case (cmd.op)
         OP_LOAD: begin
            if (count_ff < MAXC) begin
               count_in = count_ff + CW'(1);
            end else begin
               drop_in = 1'b1;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
            drop_in  = 1'b0;
         end
         OP_SORT_INIT: a_in = CW'(1);
         OP_KEY_CAP: begin
            key_in = rd_data;
            p_in   = a_ff;
         end
         OP_SHIFT:  p_in = p_ff - CW'(1);
         OP_KEY_WR: a_in = a_ff + CW'(1);
         OP_SRCH_INIT: begin
            i_in = '0;
            j_in = XW'(1);
            l_in = XW'(2);
            r_in = nx - XW'(1);
         end
         OP_INC_I: i_in = i_ff + XW'(1);
         OP_ADV_I: begin
            i_in = i_ff + XW'(1);
            j_in = i_ff + XW'(2);
            l_in = i_ff + XW'(3);
            r_in = nx - XW'(1);
         end
         OP_INC_J: j_in = j_ff + XW'(1);
         OP_ADV_J: begin
            j_in = j_ff + XW'(1);
            l_in = j_ff + XW'(2);
            r_in = nx - XW'(1);
         end
         OP_INC_L: l_in = l_ff + XW'(1);
         OP_DEC_R: r_in = r_ff - XW'(1);
         OP_FIN: begin
            l_in = l_ff + XW'(1);
            r_in = r_ff - XW'(1);
         end
         OP_SUM: sum_in = 34'(vi_ff) + 34'(vj_ff) + 34'(vl_ff) + 34'(vr_ff);
         OP_OUT_HIT: begin
            o_found_in = 1'b1;
            o_nm_in    = 1'b0;
            o_ovf_in   = drop_ff;
            o0_in = vi_ff; o1_in = vj_ff; o2_in = vl_ff; o3_in = vr_ff;
         end
         OP_OUT_MISS: begin
            o_found_in = 1'b0;
            o_nm_in    = 1'b1;
            o_ovf_in   = drop_ff;
            o0_in = '0; o1_in = '0; o2_in = '0; o3_in = '0;
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         drop_ff   <= 1'b0;
         target_ff <= '0;
      end else begin
         count_ff  <= count_in;
         drop_ff   <= drop_in;
         target_ff <= target_in;
      end
      a_ff <= a_in; p_ff <= p_in;
      i_ff <= i_in; j_ff <= j_in; l_ff <= l_in; r_ff <= r_in;
      vi_ff <= vi_in; vj_ff <= vj_in; vl_ff <= vl_in; vr_ff <= vr_in;
      tmp_ff <= tmp_in; key_ff <= key_in;
      sum_ff <= sum_in;
      o_found_ff <= o_found_in; o_nm_ff <= o_nm_in; o_ovf_ff <= o_ovf_in;
      o0_ff <= o0_in; o1_ff <= o1_in; o2_ff <= o2_in; o3_ff <= o3_in;
   end

   always_comb begin
      sts.a_lt_n     = (a_ff < count_ff);
      sts.p_nz       = (p_ff != '0);
      sts.tmp_gt_key = (tmp_ff > key_ff);
      sts.i3_ge_n    = (i_ff + XW'(3) >= nx);
      sts.j2_ge_n    = (j_ff + XW'(2) >= nx);
      sts.l_lt_r     = (l_ff < r_ff);
      sts.i1_lt_n    = (i_ff + XW'(1) < nx);
      sts.j1_lt_n    = (j_ff + XW'(1) < nx);
      sts.eq_it      = (vi_ff == tmp_ff);
      sts.eq_jt      = (vj_ff == tmp_ff);
      sts.eq_lt      = (vl_ff == tmp_ff);
      sts.eq_rt      = (vr_ff == tmp_ff);
      sts.sum_eq     = (sum_ff == tgt34);
      sts.sum_gt     = (sum_ff > tgt34);
   end

   assign rsp_found        = o_found_ff;
   assign rsp_first_value  = o0_ff;
   assign rsp_second_value = o1_ff;
   assign rsp_third_value  = o2_ff;
   assign rsp_fourth_value = o3_ff;
   assign rsp_no_more      = o_nm_ff;
   assign rsp_overflowed   = o_ovf_ff;

endmodule
`default_nettype wire

// ===== rtl/core/fsq_ctrl.sv =====
`default_nettype none
module fsq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_type,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   output fsq_pkg::cmd_type      cmd,
   input  wire fsq_pkg::sts_type sts
);
   import fsq_pkg::*;

   typedef enum logic [1:0] {
      PH_LOADING,
      PH_SEARCH,
      PH_DONE
   } phase_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_S_INIT, ST_S_A, ST_S_KEY, ST_S_P, ST_S_PCAP, ST_S_PTST, ST_S_WK,
      ST_W_TOP,
      ST_IS_RD, ST_IS_CAP, ST_IS_CHK, ST_IS_TMP, ST_IS_TST,
      ST_JS_RD, ST_JS_CAP, ST_JS_CHK, ST_JS_TMP, ST_JS_TST,
      ST_E_RI, ST_E_RJ, ST_E_RL, ST_E_RR, ST_E_CR, ST_E_SUM, ST_E_CMP,
      ST_M_CHK_L, ST_M_TMP_L, ST_M_TST_L, ST_M_CHK_R, ST_M_TMP_R, ST_M_TST_R,
      ST_M_FIN,
      ST_R_HIT, ST_R_MISS
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   // a target write never shares an edge with a request
   assign csr_ready = (state_ff == ST_IDLE) && !req_valid;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '{op: OP_NONE, rsel: RSEL_A, cap: CAP_NONE, csr_we: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  REQ_LOAD: begin
                     cmd.op   = OP_LOAD;
                     phase_in = PH_LOADING;
                  end
                  REQ_CLEAR: begin
                     cmd.op   = OP_CLEAR;
                     phase_in = PH_LOADING;
                  end
                  REQ_FETCH: begin
                     case (phase_ff)
                        PH_LOADING: state_in = ST_S_INIT;
                        PH_SEARCH:  state_in = ST_W_TOP;
                        default:    state_in = ST_R_MISS;
                     endcase
                  end
                  default: state_in = ST_IDLE;
               endcase
            end else if (csr_valid) begin
               cmd.csr_we = 1'b1;
               phase_in   = PH_LOADING;
            end
         end

         // insertion sort, one ram access a cycle
         ST_S_INIT: begin
            cmd.op   = OP_SORT_INIT;
            state_in = ST_S_A;
         end
         ST_S_A: begin
            if (sts.a_lt_n) begin
               cmd.rsel = RSEL_A;
               state_in = ST_S_KEY;
            end else begin
               cmd.op   = OP_SRCH_INIT;
               phase_in = PH_SEARCH;
               state_in = ST_W_TOP;
            end
         end
         ST_S_KEY: begin
            cmd.op   = OP_KEY_CAP;
            state_in = ST_S_P;
         end
         ST_S_P: begin
            if (sts.p_nz) begin
               cmd.rsel = RSEL_P1;
               state_in = ST_S_PCAP;
            end else begin
               state_in = ST_S_WK;
            end
         end
         ST_S_PCAP: begin
            cmd.cap  = CAP_T;
            state_in = ST_S_PTST;
         end
         ST_S_PTST: begin
            if (sts.tmp_gt_key) begin
               cmd.op   = OP_SHIFT;
               state_in = ST_S_P;
            end else begin
               state_in = ST_S_WK;
            end
         end
         ST_S_WK: begin
            cmd.op   = OP_KEY_WR;
            state_in = ST_S_A;
         end

         ST_W_TOP: begin
            if (sts.i3_ge_n) begin
               phase_in = PH_DONE;
               state_in = ST_R_MISS;
            end else if (sts.j2_ge_n) begin
               state_in = ST_IS_RD;
            end else if (sts.l_lt_r) begin
               state_in = ST_E_RI;
            end else begin
               state_in = ST_JS_RD;
            end
         end

         // skip equal outer values
         ST_IS_RD: begin
            cmd.rsel = RSEL_I;
            state_in = ST_IS_CAP;
         end
         ST_IS_CAP: begin
            cmd.cap  = CAP_I;
            state_in = ST_IS_CHK;
         end
         ST_IS_CHK: begin
            if (sts.i1_lt_n) begin
               cmd.rsel = RSEL_I1;
               state_in = ST_IS_TMP;
            end else begin
               cmd.op   = OP_ADV_I;
               state_in = ST_W_TOP;
            end
         end
         ST_IS_TMP: begin
            cmd.cap  = CAP_T;
            state_in = ST_IS_TST;
         end
         ST_IS_TST: begin
            if (sts.eq_it) begin
               cmd.op   = OP_INC_I;
               state_in = ST_IS_CHK;
            end else begin
               cmd.op   = OP_ADV_I;
               state_in = ST_W_TOP;
            end
         end

         // skip equal second values
         ST_JS_RD: begin
            cmd.rsel = RSEL_J;
            state_in = ST_JS_CAP;
         end
         ST_JS_CAP: begin
            cmd.cap  = CAP_J;
            state_in = ST_JS_CHK;
         end
         ST_JS_CHK: begin
            if (sts.j1_lt_n) begin
               cmd.rsel = RSEL_J1;
               state_in = ST_JS_TMP;
            end else begin
               cmd.op   = OP_ADV_J;
               state_in = ST_W_TOP;
            end
         end
         ST_JS_TMP: begin
            cmd.cap  = CAP_T;
            state_in = ST_JS_TST;
         end
         ST_JS_TST: begin
            if (sts.eq_jt) begin
               cmd.op   = OP_INC_J;
               state_in = ST_JS_CHK;
            end else begin
               cmd.op   = OP_ADV_J;
               state_in = ST_W_TOP;
            end
         end

         // fetch four members back to back, each capture in the state after its address
         ST_E_RI: begin
            cmd.rsel = RSEL_I;
            state_in = ST_E_RJ;
         end
         ST_E_RJ: begin
            cmd.rsel = RSEL_J;
            cmd.cap  = CAP_I;
            state_in = ST_E_RL;
         end
         ST_E_RL: begin
            cmd.rsel = RSEL_L;
            cmd.cap  = CAP_J;
            state_in = ST_E_RR;
         end
         ST_E_RR: begin
            cmd.rsel = RSEL_R;
            cmd.cap  = CAP_L;
            state_in = ST_E_CR;
         end
         ST_E_CR: begin
            cmd.cap  = CAP_R;
            state_in = ST_E_SUM;
         end
         ST_E_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_E_CMP;
         end
         ST_E_CMP: begin
            if (sts.sum_eq) begin
               state_in = ST_M_CHK_L;
            end else if (sts.sum_gt) begin
               cmd.op   = OP_DEC_R;
               state_in = ST_W_TOP;
            end else begin
               cmd.op   = OP_INC_L;
               state_in = ST_W_TOP;
            end
         end

         // after a match, step both pointers past duplicates
         ST_M_CHK_L: begin
            if (sts.l_lt_r) begin
               cmd.rsel = RSEL_L1;
               state_in = ST_M_TMP_L;
            end else begin
               state_in = ST_M_CHK_R;
            end
         end
         ST_M_TMP_L: begin
            cmd.cap  = CAP_T;
            state_in = ST_M_TST_L;
         end
         ST_M_TST_L: begin
            if (sts.eq_lt) begin
               cmd.op   = OP_INC_L;
               state_in = ST_M_CHK_L;
            end else begin
               state_in = ST_M_CHK_R;
            end
         end
         ST_M_CHK_R: begin
            if (sts.l_lt_r) begin
               cmd.rsel = RSEL_R1;
               state_in = ST_M_TMP_R;
            end else begin
               state_in = ST_M_FIN;
            end
         end
         ST_M_TMP_R: begin
            cmd.cap  = CAP_T;
            state_in = ST_M_TST_R;
         end
         ST_M_TST_R: begin
            if (sts.eq_rt) begin
               cmd.op   = OP_DEC_R;
               state_in = ST_M_CHK_R;
            end else begin
               state_in = ST_M_FIN;
            end
         end
         ST_M_FIN: begin
            cmd.op   = OP_FIN;
            state_in = ST_R_HIT;
         end

         ST_R_HIT: begin
            if (slot_free) begin
               cmd.op       = OP_OUT_HIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_R_MISS: begin
            if (slot_free) begin
               cmd.op       = OP_OUT_MISS;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LOADING;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/four_sum_quadruple_search_top.sv =====
`default_nettype none
// channel  direction  handshake                     payload
// req      in         req_valid / req_stall         req_type, req_value
// rsp      out        rsp_valid / rsp_stall         found, four values, no_more, overflowed
// csr      in         csr_valid / csr_ready         csr_target_sum
//
// load and clear are done in the idle state; one item at a time.
// the first fetch after a load, clear or target write runs an insertion sort over the
// store (one read port, one write port); each element move reads, captures, tests, shifts.
// each fetch then walks pointers, bounded by n*n*n/6 probes; a probe reads the four
// members, sums and compares them. a target write waits for an idle block.
// reset is synchronous; the store is not cleared. a held rsp word only delays the next.
module four_sum_quadruple_search_top #(
   parameter int MAX_VALUES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_type,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_found,
   output logic signed [31:0]      rsp_first_value,
   output logic signed [31:0]      rsp_second_value,
   output logic signed [31:0]      rsp_third_value,
   output logic signed [31:0]      rsp_fourth_value,
   output logic                    rsp_no_more,
   output logic                    rsp_overflowed,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic signed [31:0] csr_target_sum
);
   import fsq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fsq_dp #(
      .MAX_VALUES (MAX_VALUES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_value        (req_value),
      .csr_target_sum   (csr_target_sum),
      .rsp_found        (rsp_found),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value),
      .rsp_third_value  (rsp_third_value),
      .rsp_fourth_value (rsp_fourth_value),
      .rsp_no_more      (rsp_no_more),
      .rsp_overflowed   (rsp_overflowed)
   );

`include "four_sum_quadruple_search_top_assert.svh"

   `FSQ_ASSERT_NOW(a_hit_not_last, rsp_valid && rsp_found, !rsp_no_more, "hit marked last")
   `FSQ_ASSERT_NOW(a_miss_last, rsp_valid && !rsp_found, rsp_no_more, "miss not last")
   `FSQ_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_found, rsp_first_value == '0, "miss not zero")
   `FSQ_ASSERT_NEXT(a_fetch, req_valid && !req_stall && req_type == REQ_FETCH, req_stall, "fetch idle")

endmodule
`default_nettype wire
